### src/gnms_pkg.sv
// ----------------------------------------------------------------------------
// Gradient non-maximum suppression: shared definitions
// Sizes, codes, pipeline structs and the direction quantizer used by the
// suppression core and its submodules.
// ----------------------------------------------------------------------------
package gnms_pkg;

  // Frame and payload sizes.
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int MAG_BITS    = 16;
  localparam int GRAD_BITS   = 16;
  localparam int CFG_BITS    = 11;
  localparam int COORD_BITS  = 10;
  localparam int SECTOR_BITS = 2;
  localparam int DIM_MIN     = 3;

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int ROW_BITS = $clog2(MAX_HEIGHT);
  localparam int POS_BITS = (COL_BITS > ROW_BITS) ? COL_BITS : ROW_BITS;
  localparam int CMP_BITS = (POS_BITS + 1 > CFG_BITS) ? POS_BITS + 1 : CFG_BITS;

  // Result queue between the window stage and the output channel.
  localparam int QUEUE_DEPTH = 3;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = CFG_IDX_BITS'(1);

  // Input beat command.
  typedef enum logic {
    CMD_DATA  = 1'b0,
    CMD_FLUSH = 1'b1
  } command_t;

  // Quantized gradient direction.
  typedef enum logic [SECTOR_BITS-1:0] {
    SEC_0DEG   = 2'd0,
    SEC_45DEG  = 2'd1,
    SEC_90DEG  = 2'd2,
    SEC_135DEG = 2'd3
  } sector_t;

  typedef logic [COL_BITS-1:0] col_t;

  // Beat moving from the position sequencer into the window stage.
  typedef struct packed {
    logic                  data;      // pixel written to the line buffers
    logic                  emit;      // beat produces a result
    logic                  use_line;  // center sector comes from the sector line
    logic                  border;    // center pixel lies on the frame border
    logic                  last;      // last result of the frame
    col_t                  col;       // column of the incoming pixel
    logic [MAG_BITS-1:0]   mag;
    sector_t               sector;
    logic [COORD_BITS-1:0] row_q;
    logic [COORD_BITS-1:0] col_q;
  } stage_t;

  // Line buffer read request issued with an accepted beat.
  typedef struct packed {
    logic mag_en;
    logic sec_en;
    col_t mag_addr;
    col_t sec_addr;
  } line_rd_t;

  // Line buffer write-back from the window stage.
  typedef struct packed {
    logic                  en;
    col_t                  addr;
    logic [2*MAG_BITS-1:0] mag;
    sector_t               sector;
  } line_wr_t;

  // One result beat.
  typedef struct packed {
    logic [MAG_BITS-1:0]   kept_magnitude;
    sector_t               sector;
    logic [COORD_BITS-1:0] out_row;
    logic [COORD_BITS-1:0] out_col;
    logic                  frame_end;
  } result_t;

  // Clamp a frame dimension to DIM_MIN..hi.
  function automatic logic [CFG_BITS-1:0] clamp_dim(input logic [CFG_BITS-1:0] v,
                                                    input int unsigned hi);
    logic [CFG_BITS-1:0] r;
    r = v;
    if (v < CFG_BITS'(DIM_MIN)) begin
      r = CFG_BITS'(DIM_MIN);
    end else if (32'(v) > hi) begin
      r = CFG_BITS'(hi);
    end
    return r;
  endfunction

  localparam logic [CFG_BITS-1:0] RESET_WIDTH  = clamp_dim(CFG_BITS'(640), MAX_WIDTH);
  localparam logic [CFG_BITS-1:0] RESET_HEIGHT = clamp_dim(CFG_BITS'(480), MAX_HEIGHT);

  // Direction sector of a gradient: the octant of its angle folded mod 4.
  // Only exact comparisons are used; a zero gradient falls into sector 0.
  function automatic sector_t sector_of(input logic signed [GRAD_BITS-1:0] gx,
                                        input logic signed [GRAD_BITS-1:0] gy);
    logic signed [GRAD_BITS:0] x;
    logic signed [GRAD_BITS:0] y;
    logic signed [GRAD_BITS:0] nx;
    logic signed [GRAD_BITS:0] ny;
    sector_t s;
    x  = (GRAD_BITS + 1)'(gx);
    y  = (GRAD_BITS + 1)'(gy);
    nx = -x;
    ny = -y;
    if (x == 0 && y == 0) begin
      s = SEC_0DEG;
    end else if (y >= 0) begin
      if (x > 0) begin
        s = (y < x) ? SEC_0DEG : SEC_45DEG;
      end else if (y == 0) begin
        s = SEC_0DEG;
      end else begin
        s = (y > nx) ? SEC_90DEG : SEC_135DEG;
      end
    end else if (x < 0) begin
      s = (ny < nx) ? SEC_0DEG : SEC_45DEG;
    end else begin
      s = (ny > x) ? SEC_90DEG : SEC_135DEG;
    end
    return s;
  endfunction

endpackage

### src/gnms_if.sv
// ----------------------------------------------------------------------------
// Gradient non-maximum suppression: channel interfaces
// Pixel input, result output and configuration write channels, each with
// valid/ready and its payload.
// ----------------------------------------------------------------------------
interface gnms_pix_if import gnms_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic signed [GRAD_BITS-1:0] grad_x;
  logic signed [GRAD_BITS-1:0] grad_y;
  logic [MAG_BITS-1:0]         magnitude;

  modport source (output valid, command, grad_x, grad_y, magnitude, input ready);
  modport sink   (input valid, command, grad_x, grad_y, magnitude, output ready);
endinterface

interface gnms_res_if import gnms_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [MAG_BITS-1:0]    kept_magnitude;
  logic [SECTOR_BITS-1:0] sector;
  logic [COORD_BITS-1:0]  out_row;
  logic [COORD_BITS-1:0]  out_col;
  logic                   frame_end;

  modport source (output valid, kept_magnitude, sector, out_row, out_col, frame_end,
                  input ready);
  modport sink   (input valid, kept_magnitude, sector, out_row, out_col, frame_end,
                  output ready);
endinterface

interface gnms_cfg_if import gnms_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [CFG_BITS-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/gnms_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered and returns the
// old contents when the same address is written in the same cycle.
// ----------------------------------------------------------------------------
module gnms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/gnms_seq.sv
// ----------------------------------------------------------------------------
// Gradient non-maximum suppression: position sequencer
// Holds the frame size registers and the input/output raster positions,
// decodes each accepted beat, issues line buffer reads and loads the
// window stage register.
// ----------------------------------------------------------------------------
module gnms_seq import gnms_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [CFG_BITS-1:0]         cfg_data,
  input  logic                        fire,
  input  logic                        command,
  input  logic signed [GRAD_BITS-1:0] grad_x,
  input  logic signed [GRAD_BITS-1:0] grad_y,
  input  logic [MAG_BITS-1:0]         magnitude,
  output line_rd_t                    line_rd,
  output stage_t                      stage
);

  logic [CFG_BITS-1:0] width;
  logic [CFG_BITS-1:0] height;
  logic [ROW_BITS-1:0] in_row;
  logic [ROW_BITS-1:0] in_row_next;
  logic [ROW_BITS-1:0] out_row;
  logic [ROW_BITS-1:0] out_row_next;
  col_t                in_col;
  col_t                in_col_next;
  col_t                out_col;
  col_t                out_col_next;
  logic                in_done;
  logic                in_done_next;
  stage_t              stage_next;

  logic is_data;
  logic is_flush;
  logic cfg_hit;
  logic data_emit;
  logic in_last_col;
  logic in_last_row;
  logic out_last_col;
  logic out_last_row;

  function automatic logic col_is_last(input col_t c, input logic [CFG_BITS-1:0] w);
    return (CMP_BITS'(c) + CMP_BITS'(1)) == CMP_BITS'(w);
  endfunction

  function automatic logic row_is_last(input logic [ROW_BITS-1:0] r,
                                       input logic [CFG_BITS-1:0] h);
    return (CMP_BITS'(r) + CMP_BITS'(1)) == CMP_BITS'(h);
  endfunction

  assign cfg_hit = cfg_we && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT);

  // Beat decode. Data past a full frame and a flush before it are dropped.
  always_comb begin
    is_data      = fire && (command == CMD_DATA) && !in_done;
    is_flush     = fire && (command == CMD_FLUSH) && in_done;
    in_last_col  = col_is_last(in_col, width);
    in_last_row  = row_is_last(in_row, height);
    out_last_col = col_is_last(out_col, width);
    out_last_row = row_is_last(out_row, height);
    // A result trails its input by one row and one column.
    data_emit    = (in_row >= ROW_BITS'(2)) || (in_row == ROW_BITS'(1) && in_col != '0);

    stage_next.data     = is_data;
    stage_next.emit     = (is_data && data_emit) || is_flush;
    stage_next.use_line = is_flush && out_last_row;
    stage_next.border   = (out_row == '0) || (out_col == '0) || out_last_row || out_last_col;
    stage_next.last     = is_flush && out_last_row && out_last_col;
    stage_next.col      = in_col;
    stage_next.mag      = magnitude;
    stage_next.sector   = sector_of(grad_x, grad_y);
    stage_next.row_q    = COORD_BITS'(out_row);
    stage_next.col_q    = COORD_BITS'(out_col);

    line_rd.mag_en   = is_data;
    line_rd.mag_addr = in_col;
    line_rd.sec_en   = is_data || is_flush;
    line_rd.sec_addr = is_flush ? out_col : in_col;
  end

  // Raster position update.
  always_comb begin
    in_row_next  = in_row;
    in_col_next  = in_col;
    in_done_next = in_done;
    out_row_next = out_row;
    out_col_next = out_col;
    if (is_data) begin
      if (in_last_col) begin
        in_col_next = '0;
        if (in_last_row) begin
          in_done_next = 1'b1;
        end else begin
          in_row_next = in_row + ROW_BITS'(1);
        end
      end else begin
        in_col_next = in_col + col_t'(1);
      end
    end
    if (stage_next.emit) begin
      if (stage_next.last) begin
        // Frame done: both positions return to the origin.
        in_row_next  = '0;
        in_col_next  = '0;
        in_done_next = 1'b0;
        out_row_next = '0;
        out_col_next = '0;
      end else if (out_last_col) begin
        out_col_next = '0;
        out_row_next = out_row + ROW_BITS'(1);
      end else begin
        out_col_next = out_col + col_t'(1);
      end
    end
  end

  // Registers. A size write abandons the frame in progress.
  always_ff @(posedge clk) begin
    if (rst) begin
      width   <= RESET_WIDTH;
      height  <= RESET_HEIGHT;
      in_row  <= '0;
      in_col  <= '0;
      in_done <= 1'b0;
      out_row <= '0;
      out_col <= '0;
      stage   <= '0;
    end else begin
      stage <= stage_next;
      if (cfg_hit) begin
        if (cfg_index == CFG_FRAME_WIDTH) begin
          width <= clamp_dim(cfg_data, MAX_WIDTH);
        end else begin
          height <= clamp_dim(cfg_data, MAX_HEIGHT);
        end
        in_row  <= '0;
        in_col  <= '0;
        in_done <= 1'b0;
        out_row <= '0;
        out_col <= '0;
      end else begin
        in_row  <= in_row_next;
        in_col  <= in_col_next;
        in_done <= in_done_next;
        out_row <= out_row_next;
        out_col <= out_col_next;
      end
    end
  end

endmodule

### src/gnms_window.sv
// ----------------------------------------------------------------------------
// Gradient non-maximum suppression: 3x3 window stage
// Forms the window from the line buffer read data and the incoming pixel,
// writes the pixel column back to the line buffers and decides whether the
// center pixel is a local maximum along its direction.
// ----------------------------------------------------------------------------
module gnms_window import gnms_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  stage_t                 stage,
  input  logic [2*MAG_BITS-1:0]  mag_rdata,
  input  logic [SECTOR_BITS-1:0] sec_rdata,
  output line_wr_t               line_wr,
  output logic                   res_push,
  output result_t                res_data
);

  // Left and middle window columns; the right column comes straight in.
  logic [MAG_BITS-1:0] l_top;
  logic [MAG_BITS-1:0] l_mid;
  logic [MAG_BITS-1:0] l_bot;
  logic [MAG_BITS-1:0] m_top;
  logic [MAG_BITS-1:0] m_mid;
  logic [MAG_BITS-1:0] m_bot;
  sector_t             s_mid;

  logic [MAG_BITS-1:0] r_top;
  logic [MAG_BITS-1:0] r_mid;
  logic [MAG_BITS-1:0] r_bot;
  logic [MAG_BITS-1:0] n_a;
  logic [MAG_BITS-1:0] n_b;
  logic [MAG_BITS-1:0] kept;
  sector_t             sec_c;

  always_comb begin
    r_top = mag_rdata[2*MAG_BITS-1:MAG_BITS];
    r_mid = mag_rdata[MAG_BITS-1:0];
    r_bot = stage.mag;

    // On the final flush row the center sector is read back from the line.
    sec_c = stage.use_line ? sector_t'(sec_rdata) : s_mid;

    // Pick the two neighbors along the center's direction.
    unique case (sec_c)
      SEC_0DEG: begin
        n_a = l_mid;
        n_b = r_mid;
      end
      SEC_45DEG: begin
        n_a = r_bot;
        n_b = l_top;
      end
      SEC_90DEG: begin
        n_a = m_top;
        n_b = m_bot;
      end
      SEC_135DEG: begin
        n_a = l_bot;
        n_b = r_top;
      end
    endcase

    kept = (!stage.border && m_mid > n_a && m_mid > n_b) ? m_mid : '0;

    res_push                = stage.emit;
    res_data.kept_magnitude = kept;
    res_data.sector         = sec_c;
    res_data.out_row        = stage.row_q;
    res_data.out_col        = stage.col_q;
    res_data.frame_end      = stage.last;

    // The older line moves up; the new pixel becomes the newer line.
    line_wr.en     = stage.data;
    line_wr.addr   = stage.col;
    line_wr.mag    = {r_mid, stage.mag};
    line_wr.sector = stage.sector;
  end

  // Shift the window one column on every data pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      l_top <= '0;
      l_mid <= '0;
      l_bot <= '0;
      m_top <= '0;
      m_mid <= '0;
      m_bot <= '0;
      s_mid <= SEC_0DEG;
    end else if (stage.data) begin
      l_top <= m_top;
      l_mid <= m_mid;
      l_bot <= m_bot;
      m_top <= r_top;
      m_mid <= r_mid;
      m_bot <= r_bot;
      s_mid <= sector_t'(sec_rdata);
    end
  end

endmodule

### src/gnms_outq.sv
// ----------------------------------------------------------------------------
// Gradient non-maximum suppression: result queue
// Small register queue that decouples the window stage from the output
// channel so that a stalled receiver does not stop the pipeline at once.
// ----------------------------------------------------------------------------
module gnms_outq import gnms_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  result_t              push_data,
  input  logic                 pop,
  output logic                 valid,
  output result_t              head,
  output logic [QCNT_BITS-1:0] count
);

  result_t              entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;

  function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
    return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_BITS'(1);
  endfunction

  assign valid = (count != '0);
  assign head  = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + QCNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_BITS'(1);
      end
    end
  end

endmodule

### src/gradient_nonmax_suppression_core.sv
// ----------------------------------------------------------------------------
// Gradient non-maximum suppression core
// Streaming Canny-style thinning of a gradient image using two line buffers.
// ----------------------------------------------------------------------------
// Usage:
//   pix carries raster-order beats: command data with grad_x, grad_y and
//   magnitude, or command flush. res carries one result per pixel: the kept
//   magnitude (zero unless a strict local maximum along its direction, zero
//   on borders), its sector, row and column, and frame_end on the last one.
//   The result for pixel (r,c) is caused by pixel (r+1,c+1); once the whole
//   frame is in, frame_width+1 flush beats drain the rest.
//   cfg writes frame_width (index 0) or frame_height (index 1), clamped to
//   3..1024; a write restarts the frame. Write it only while idle.
// Timing:
//   One beat per cycle sustained while res is not stalled; the line buffers
//   take one read and one write per cycle. A result from the window stage
//   is registered into the result queue and is offered on res from the
//   queue head.
//   When res stalls, a three-entry result queue fills and pix.ready drops.
// Reset:
//   Positions clear, size returns to 640 x 480. Line buffers are not cleared;
//   every pixel a result depends on is written earlier in the same frame.
// ----------------------------------------------------------------------------
module gradient_nonmax_suppression_core import gnms_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  gnms_cfg_if.sink   cfg,
  gnms_pix_if.sink   pix,
  gnms_res_if.source res
);

  logic                   pix_fire;
  logic                   cfg_we;
  line_rd_t               line_rd;
  line_wr_t               line_wr;
  stage_t                 stage;
  logic [2*MAG_BITS-1:0]  mag_rdata;
  logic [SECTOR_BITS-1:0] sec_rdata;
  logic                   res_push;
  result_t                res_data;
  logic                   q_valid;
  logic                   q_pop;
  result_t                q_head;
  logic [QCNT_BITS-1:0]   q_count;
  logic [QCNT_BITS:0]     q_load;

  // Accept only while the queue has room for everything already in flight.
  assign q_load    = (QCNT_BITS + 1)'(q_count) + (QCNT_BITS + 1)'(stage.emit);
  assign pix.ready = !rst && (q_load < (QCNT_BITS + 1)'(QUEUE_DEPTH));
  assign cfg.ready = !rst;
  assign pix_fire  = pix.valid && pix.ready;
  assign cfg_we    = cfg.valid && cfg.ready;

  gnms_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .fire      (pix_fire),
    .command   (pix.command),
    .grad_x    (pix.grad_x),
    .grad_y    (pix.grad_y),
    .magnitude (pix.magnitude),
    .line_rd   (line_rd),
    .stage     (stage)
  );

  // Two magnitude lines packed side by side, one word per column.
  gnms_ram #(
    .WIDTH (2 * MAG_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_mag_ram (
    .clk   (clk),
    .we    (line_wr.en),
    .waddr (line_wr.addr),
    .wdata (line_wr.mag),
    .re    (line_rd.mag_en),
    .raddr (line_rd.mag_addr),
    .rdata (mag_rdata)
  );

  // Sector of the previous row, one entry per column.
  gnms_ram #(
    .WIDTH (SECTOR_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_sec_ram (
    .clk   (clk),
    .we    (line_wr.en),
    .waddr (line_wr.addr),
    .wdata (line_wr.sector),
    .re    (line_rd.sec_en),
    .raddr (line_rd.sec_addr),
    .rdata (sec_rdata)
  );

  gnms_window u_window (
    .clk       (clk),
    .rst       (rst),
    .stage     (stage),
    .mag_rdata (mag_rdata),
    .sec_rdata (sec_rdata),
    .line_wr   (line_wr),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  gnms_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_data),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head),
    .count     (q_count)
  );

  // Output channel.
  assign q_pop              = res.valid && res.ready;
  assign res.valid          = q_valid;
  assign res.kept_magnitude = q_head.kept_magnitude;
  assign res.sector         = q_head.sector;
  assign res.out_row        = q_head.out_row;
  assign res.out_col        = q_head.out_col;
  assign res.frame_end      = q_head.frame_end;

  // The queue never receives a result while it is full.
  assert property (@(posedge clk) disable iff (rst)
    res_push |-> (q_count != QCNT_BITS'(QUEUE_DEPTH)))
    else $error("result queue overflow");

  // A line buffer write-back never collides with a read of the same column.
  assert property (@(posedge clk) disable iff (rst)
    (line_wr.en && line_rd.mag_en) |-> (line_wr.addr != line_rd.mag_addr))
    else $error("line buffer read and write hit the same column");

  // Every result in the window stage comes from a beat accepted the cycle before.
  assert property (@(posedge clk) disable iff (rst)
    stage.emit |-> $past(pix_fire))
    else $error("result without an accepted beat");

  // The last pixel of a frame is a corner and is never kept.
  assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.frame_end) |-> (res.kept_magnitude == '0))
    else $error("frame end result carries a kept magnitude");

endmodule
